// ===== hdl/sfbtm_pkg.sv =====
// Package for the strip front/back time matcher.
// Holds field widths, codes, hit and result types and the energy test function.
// No dependencies.
package sfbtm_pkg;

  localparam int ENERGY_W = 18;
  localparam int TIME_W   = 48;
  localparam int STRIP_W  = 8;
  localparam int WINDOW_W = 24;
  localparam int OP_W     = 2;
  localparam int KIND_W   = 2;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;

  localparam logic [ENERGY_W-1:0] SAT_TEST_KEV   = 18'd20000;
  localparam logic [ENERGY_W-1:0] DELTA_RESET    = 18'd1000;
  localparam logic [ENERGY_W-1:0] HIGH_CUT_RESET = 18'd20000;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET   = 24'd100;

  localparam logic [OP_W-1:0] OP_LOAD_BACK  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_FRONT = 2'd1;
  localparam logic [OP_W-1:0] OP_END_EVENT  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_PAIR        = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BACK_ALONE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FRONT_ALONE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_EMPTY       = 2'd3;

  localparam logic [1:0] REG_DELTA_ENERGY = 2'd0;
  localparam logic [1:0] REG_HIGH_CUT     = 2'd1;
  localparam logic [1:0] REG_TIME_WINDOW  = 2'd2;

  typedef struct packed {
    logic [ENERGY_W-1:0] energy;
    logic [TIME_W-1:0]   timestamp;
    logic [STRIP_W-1:0]  strip;
    logic                sat;
  } hit_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    hit_t              back;
    hit_t              front;
    logic              overflow;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BRD,
    S_BEX,
    S_FRD,
    S_FEV,
    S_FCMP,
    S_DEC,
    S_UBRD,
    S_UBOUT,
    S_UFRD,
    S_UFOUT,
    S_FLUSH
  } state_t;

  // Saturated hits and hits above the cut take part in the energy test as 20000 keV.
  function automatic logic [ENERGY_W-1:0] test_energy(input logic [ENERGY_W-1:0] e,
                                                      input logic sat,
                                                      input logic [ENERGY_W-1:0] cut);
    test_energy = (sat || (e > cut)) ? SAT_TEST_KEV : e;
  endfunction

endpackage

// ===== hdl/strip_front_back_time_matcher_top.sv =====
// Strip front/back time matcher: hit stores, matching sequencer, result register, APB registers.
// Depends on sfbtm_pkg.
//
// Usage: an item is taken at a rising edge with start high and busy low. Opcode 0 stores a
// back hit, opcode 1 a front hit; busy stays low during a load. A hit that finds its store
// full is dropped and the event's overflow flag is set. Opcode 2 ends the event and raises
// busy while one shared energy and time comparator walks the stores: for each back hit it
// reads every unused front hit in turn, skipping used ones, and keeps the closest eligible
// one. Unmatched back and front hits are then read out. Results leave on the result ports,
// one cycle each, marked by valid, with last on the final one; the receiver cannot stall
// them. A result is held one step so that last is known when it leaves. An event with no
// hits gives one empty-event result.
// Reset empties the stores, clears the overflow flag and restores the register defaults.
// Registers sit on the APB port at byte addresses 0 (delta_energy), 4 (high_energy_cut)
// and 8 (time_window); write them only while the block is idle.
module strip_front_back_time_matcher_top #(
  parameter int MAX_BACK_HITS  = 16,
  parameter int MAX_FRONT_HITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sfbtm_pkg::ADDR_W-1:0]      paddr,
  input  logic [sfbtm_pkg::DATA_W-1:0]      pwdata,
  output logic [sfbtm_pkg::DATA_W-1:0]      prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  logic [sfbtm_pkg::OP_W-1:0]        opcode,
  input  logic [sfbtm_pkg::ENERGY_W-1:0]    energy,
  input  logic [sfbtm_pkg::TIME_W-1:0]      timestamp,
  input  logic [sfbtm_pkg::STRIP_W-1:0]     strip,
  input  logic                              saturated,
  output logic                              valid,
  output logic [sfbtm_pkg::KIND_W-1:0]      kind,
  output logic [sfbtm_pkg::STRIP_W-1:0]     back_strip,
  output logic [sfbtm_pkg::STRIP_W-1:0]     front_strip,
  output logic [sfbtm_pkg::ENERGY_W-1:0]    back_energy,
  output logic [sfbtm_pkg::ENERGY_W-1:0]    front_energy,
  output logic [sfbtm_pkg::TIME_W-1:0]      back_time,
  output logic [sfbtm_pkg::TIME_W-1:0]      front_time,
  output logic                              back_sat,
  output logic                              front_sat,
  output logic                              overflow,
  output logic                              last
);
  import sfbtm_pkg::*;

  localparam int BAW = (MAX_BACK_HITS > 1) ? $clog2(MAX_BACK_HITS) : 1;
  localparam int FAW = (MAX_FRONT_HITS > 1) ? $clog2(MAX_FRONT_HITS) : 1;
  localparam int BCW = $clog2(MAX_BACK_HITS + 1);
  localparam int FCW = $clog2(MAX_FRONT_HITS + 1);
  localparam logic [BCW-1:0] BACK_FULL  = BCW'(MAX_BACK_HITS);
  localparam logic [FCW-1:0] FRONT_FULL = FCW'(MAX_FRONT_HITS);

  // Configuration registers
  logic [ENERGY_W-1:0] delta_energy;
  logic [ENERGY_W-1:0] high_energy_cut;
  logic [WINDOW_W-1:0] time_window;

  // Control state
  state_t              state;
  state_t              state_next;
  logic [BCW-1:0]      back_count;
  logic [FCW-1:0]      front_count;
  logic                overflow_flag;
  logic [BCW-1:0]      bi;
  logic [FCW-1:0]      fj;
  logic [MAX_BACK_HITS-1:0]  back_used;
  logic [MAX_FRONT_HITS-1:0] front_used;
  logic                found;
  logic                pend_valid;

  // Datapath
  hit_t                back_mem [MAX_BACK_HITS];
  hit_t                front_mem [MAX_FRONT_HITS];
  hit_t                back_rd;
  hit_t                front_rd;
  hit_t                back_cur;
  hit_t                cand;
  hit_t                best_hit;
  logic [ENERGY_W-1:0] ex;
  logic                e_ok;
  logic [TIME_W-1:0]   dt;
  logic [TIME_W-1:0]   best_dt;
  logic [FAW-1:0]      best_j;
  result_t             pend;
  result_t             res;
  logic                res_last;

  // Combinational control
  logic                accept;
  logic                end_accept;
  logic                push;
  result_t             push_res;
  logic                match;
  logic                bi_end;
  logic                fj_end;
  logic [ENERGY_W-1:0] ey;
  logic [ENERGY_W-1:0] de;
  hit_t                hit_in;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign end_accept = accept && (opcode == OP_END_EVENT);
  assign bi_end     = (bi == back_count);
  assign fj_end     = (fj == front_count);
  assign match      = found && (best_dt < {{(TIME_W - WINDOW_W){1'b0}}, time_window});
  assign hit_in     = '{energy: energy, timestamp: timestamp, strip: strip, sat: saturated};

  // Energy and time difference unit, shared by every back/front comparison.
  assign ey = test_energy(front_rd.energy, front_rd.sat, high_energy_cut);
  assign de = (ex > ey) ? (ex - ey) : (ey - ex);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (end_accept) begin
          state_next = (back_count == '0 && front_count == '0) ? S_FLUSH : S_BRD;
        end
      end
      S_BRD:   state_next = bi_end ? S_UBRD : S_BEX;
      S_BEX:   state_next = S_FRD;
      S_FRD: begin
        if (fj_end) begin
          state_next = S_DEC;
        end else if (!front_used[fj[FAW-1:0]]) begin
          state_next = S_FEV;
        end
      end
      S_FEV:   state_next = S_FCMP;
      S_FCMP:  state_next = S_FRD;
      S_DEC:   state_next = S_BRD;
      S_UBRD: begin
        if (bi_end) begin
          state_next = S_UFRD;
        end else if (!back_used[bi[BAW-1:0]]) begin
          state_next = S_UBOUT;
        end
      end
      S_UBOUT: state_next = S_UBRD;
      S_UFRD: begin
        if (fj_end) begin
          state_next = S_FLUSH;
        end else if (!front_used[fj[FAW-1:0]]) begin
          state_next = S_UFOUT;
        end
      end
      S_UFOUT: state_next = S_UFRD;
      S_FLUSH: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    push     = 1'b0;
    push_res = '{kind: KIND_EMPTY, back: '0, front: '0, overflow: overflow_flag};
    case (state)
      S_IDLE: begin
        if (end_accept && back_count == '0 && front_count == '0) begin
          push = 1'b1;
        end
      end
      S_DEC: begin
        if (match) begin
          push           = 1'b1;
          push_res.kind  = KIND_PAIR;
          push_res.back  = back_cur;
          push_res.front = best_hit;
        end
      end
      S_UBOUT: begin
        push          = 1'b1;
        push_res.kind = KIND_BACK_ALONE;
        push_res.back = back_rd;
      end
      S_UFOUT: begin
        push           = 1'b1;
        push_res.kind  = KIND_FRONT_ALONE;
        push_res.front = front_rd;
      end
      default: push = 1'b0;
    endcase
  end

  // APB register file
  assign pready = 1'b1;

  always_comb begin
    case (paddr[3:2])
      REG_DELTA_ENERGY: prdata = DATA_W'(delta_energy);
      REG_HIGH_CUT:     prdata = DATA_W'(high_energy_cut);
      REG_TIME_WINDOW:  prdata = DATA_W'(time_window);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delta_energy    <= DELTA_RESET;
      high_energy_cut <= HIGH_CUT_RESET;
      time_window     <= WINDOW_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_DELTA_ENERGY: delta_energy    <= pwdata[ENERGY_W-1:0];
        REG_HIGH_CUT:     high_energy_cut <= pwdata[ENERGY_W-1:0];
        REG_TIME_WINDOW:  time_window     <= pwdata[WINDOW_W-1:0];
        default:          ;
      endcase
    end
  end

  // Hit stores: written on loads, read every cycle at the walk counters.
  always_ff @(posedge clk) begin
    if (accept && opcode == OP_LOAD_BACK && back_count != BACK_FULL) begin
      back_mem[back_count[BAW-1:0]] <= hit_in;
    end
    if (accept && opcode == OP_LOAD_FRONT && front_count != FRONT_FULL) begin
      front_mem[front_count[FAW-1:0]] <= hit_in;
    end
    back_rd  <= back_mem[bi[BAW-1:0]];
    front_rd <= front_mem[fj[FAW-1:0]];
  end

  // Sequencer counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      back_count    <= '0;
      front_count   <= '0;
      overflow_flag <= 1'b0;
      bi            <= '0;
      fj            <= '0;
      back_used     <= '0;
      front_used    <= '0;
      found         <= 1'b0;
      pend_valid    <= 1'b0;
      valid         <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept && opcode == OP_LOAD_BACK) begin
            if (back_count != BACK_FULL) begin
              back_count <= back_count + 1'b1;
            end else begin
              overflow_flag <= 1'b1;
            end
          end
          if (accept && opcode == OP_LOAD_FRONT) begin
            if (front_count != FRONT_FULL) begin
              front_count <= front_count + 1'b1;
            end else begin
              overflow_flag <= 1'b1;
            end
          end
          if (end_accept) begin
            bi         <= '0;
            fj         <= '0;
            back_used  <= '0;
            front_used <= '0;
          end
        end
        S_BRD: begin
          if (bi_end) begin
            bi <= '0;
          end
        end
        S_BEX: begin
          found <= 1'b0;
          fj    <= '0;
        end
        S_FRD: begin
          if (!fj_end && front_used[fj[FAW-1:0]]) begin
            fj <= fj + 1'b1;
          end
        end
        S_FCMP: begin
          if (e_ok && (!found || dt < best_dt)) begin
            found <= 1'b1;
          end
          fj <= fj + 1'b1;
        end
        S_DEC: begin
          if (match) begin
            back_used[bi[BAW-1:0]] <= 1'b1;
            front_used[best_j]     <= 1'b1;
          end
          bi <= bi + 1'b1;
        end
        S_UBRD: begin
          if (bi_end) begin
            fj <= '0;
          end else if (back_used[bi[BAW-1:0]]) begin
            bi <= bi + 1'b1;
          end
        end
        S_UBOUT: bi <= bi + 1'b1;
        S_UFRD: begin
          if (!fj_end && front_used[fj[FAW-1:0]]) begin
            fj <= fj + 1'b1;
          end
        end
        S_UFOUT: fj <= fj + 1'b1;
        S_FLUSH: begin
          back_count    <= '0;
          front_count   <= '0;
          overflow_flag <= 1'b0;
        end
        default: ;
      endcase

      // The newest result waits in pend until the next one shows it was not the last.
      if (push) begin
        pend_valid <= 1'b1;
        valid      <= pend_valid;
      end else if (state == S_FLUSH) begin
        pend_valid <= 1'b0;
        valid      <= 1'b1;
      end else begin
        valid      <= 1'b0;
      end
    end
  end

  // Comparison datapath and result registers
  always_ff @(posedge clk) begin
    if (state == S_BEX) begin
      back_cur <= back_rd;
      ex       <= test_energy(back_rd.energy, back_rd.sat, high_energy_cut);
    end
    if (state == S_FEV) begin
      cand <= front_rd;
      e_ok <= (de <= delta_energy);
      dt   <= (back_cur.timestamp > front_rd.timestamp) ?
              (back_cur.timestamp - front_rd.timestamp) :
              (front_rd.timestamp - back_cur.timestamp);
    end
    if (state == S_FCMP && e_ok && (!found || dt < best_dt)) begin
      best_dt  <= dt;
      best_j   <= fj[FAW-1:0];
      best_hit <= cand;
    end
    if (push) begin
      pend     <= push_res;
      res      <= pend;
      res_last <= 1'b0;
    end else if (state == S_FLUSH) begin
      res      <= pend;
      res_last <= 1'b1;
    end
  end

  assign kind         = res.kind;
  assign back_strip   = res.back.strip;
  assign front_strip  = res.front.strip;
  assign back_energy  = res.back.energy;
  assign front_energy = res.front.energy;
  assign back_time    = res.back.timestamp;
  assign front_time   = res.front.timestamp;
  assign back_sat     = res.back.sat;
  assign front_sat    = res.front.sat;
  assign overflow     = res.overflow;
  assign last         = res_last;

  a_flush_emits_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |=> (valid && last))
    else $error("flush did not deliver the last result");

  a_no_result_after_last: assert property (@(posedge clk) disable iff (rst)
    (valid && last) |=> !valid)
    else $error("result delivered right after the last one");

  a_flush_has_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> (pend_valid || push))
    else $error("event ended with no result waiting");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (back_count <= BACK_FULL) && (front_count <= FRONT_FULL))
    else $error("hit count beyond store depth");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEC && found) |-> (FCW'(best_j) < front_count))
    else $error("chosen front hit lies beyond the loaded hits");

endmodule
